### rtl/dmwbnc_pkg.sv
// ----------------------------------------------------------------------------
// dmwbnc_pkg
// Shared codes, field widths and controller/datapath handshake types for the
// direct-mapped write-back name cache.
// ----------------------------------------------------------------------------
package dmwbnc_pkg;

  // Field widths on the stream ports
  localparam int unsigned OP_W    = 3;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned S_TDATA_W = 80;  // key, data, found, slot, zero pad
  localparam int unsigned M_TDATA_W = 64;  // out_key, out_value

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_FILL   = 3'd3;
  localparam logic [OP_W-1:0] OP_FLUSH  = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_VALUE     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FETCH     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NOTFOUND  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WRITEBACK = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DELETE    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DONE      = 3'd5;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture input beat, start index calculation
    logic clear;     // write one zero entry of the clearing sweep
    logic rd;        // read the addressed slot
    logic decide;    // update slot, register results
    logic sel_main;  // present main result (else write-back)
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_done;
    logic clear_last;
    logic need_wb;
  } status_t;

endpackage

### rtl/dmwbnc_ram.sv
// ----------------------------------------------------------------------------
// dmwbnc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmwbnc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dmwbnc_slot.sv
// ----------------------------------------------------------------------------
// dmwbnc_slot
// Slot index unit: key modulo ENTRIES. Power-of-two depths register the low
// bits of the key; other depths use a reciprocal multiply and one correction,
// registering the product, the quotient times ENTRIES and the remainder.
// ----------------------------------------------------------------------------
module dmwbnc_slot #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned KW      = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [KW-1:0]              key_i,
  output logic                       done_o,
  output logic [$clog2(ENTRIES)-1:0] slot_o
);

  localparam int unsigned IW   = $clog2(ENTRIES);
  localparam bit          POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);

  if (POW2) begin : g_pow2
    logic          done_q;
    logic [IW-1:0] slot_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        slot_q <= IW'(key_i);
      end
    end

    assign done_o = done_q;
    assign slot_o = slot_q;
  end else begin : g_recip
    // q_est = floor(key * floor(2^P / N) / 2^P) is at most one short, so the
    // remainder is below 2N and needs a single subtract.
    localparam int unsigned     P     = KW + IW;
    localparam logic [63:0]     RECIP = (64'd1 << P) / 64'(ENTRIES);
    localparam logic [KW:0]     RCP_W = RECIP[KW:0];
    localparam logic [IW:0]     NVAL  = (IW + 1)'(ENTRIES);

    logic [2:0]      v_q;
    logic [2*KW:0]   prod_q;
    logic [KW-1:0]   key1_q, key2_q;
    logic [KW-1:0]   qn_q;
    logic [KW-1:0]   q_est;
    logic [KW-1:0]   rem;
    logic [KW-1:0]   rem_fix;
    logic [IW-1:0]   slot_q;

    assign q_est   = KW'(prod_q >> P);
    assign rem     = key2_q - qn_q;
    assign rem_fix = (rem >= KW'(NVAL)) ? rem - KW'(NVAL) : rem;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= '0;
      end else begin
        v_q <= {v_q[1:0], start_i};
      end
    end

    always_ff @(posedge clk_i) begin
      prod_q <= (2*KW + 1)'(key_i) * (2*KW + 1)'(RCP_W);
      key1_q <= key_i;
      qn_q   <= KW'(q_est * KW'(NVAL));
      key2_q <= key1_q;
      slot_q <= IW'(rem_fix);
    end

    assign done_o = v_q[2];
    assign slot_o = slot_q;
  end

endmodule

### rtl/dmwbnc_datapath.sv
// ----------------------------------------------------------------------------
// dmwbnc_datapath
// Item registers, slot index unit, entry RAM with its clearing sweep, the
// hit/evict decision and the result registers.
// ----------------------------------------------------------------------------
module dmwbnc_datapath #(
  parameter int unsigned ENTRIES    = 256,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  dmwbnc_pkg::cmd_t                      cmd_i,
  output dmwbnc_pkg::status_t                   status_o,
  input  logic [dmwbnc_pkg::S_TDATA_W-1:0]      s_tdata_i,
  input  logic [dmwbnc_pkg::OP_W-1:0]           s_tuser_i,
  output logic [dmwbnc_pkg::M_TDATA_W-1:0]      m_tdata_o,
  output logic [dmwbnc_pkg::KIND_W-1:0]         m_tuser_o,
  output logic                                  m_tlast_o
);

  localparam int unsigned KW = (KEY_BITS < dmwbnc_pkg::KEY_W) ? KEY_BITS : dmwbnc_pkg::KEY_W;
  localparam int unsigned VW = (VALUE_BITS < dmwbnc_pkg::VAL_W) ? VALUE_BITS : dmwbnc_pkg::VAL_W;
  localparam int unsigned IW = $clog2(ENTRIES);
  // Entry word: {valid, dirty, on_disk, key, value}
  localparam int unsigned EW = 3 + KW + VW;

  // Item registers
  logic [dmwbnc_pkg::OP_W-1:0]   op_q;
  logic [KW-1:0]                 key_q;
  logic [VW-1:0]                 data_q;
  logic                          found_q;
  logic [dmwbnc_pkg::SLOT_W-1:0] fslot_q;
  logic [IW-1:0]                 idx_q;
  logic [IW-1:0]                 clr_addr_q;

  logic [KW-1:0] key_in;
  logic [IW-1:0] slot;
  logic          slot_done;
  logic [IW-1:0] rd_addr;
  logic          in_range;

  assign key_in = KW'(s_tdata_i[31:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= s_tuser_i;
      key_q   <= key_in;
      data_q  <= VW'(s_tdata_i[63:32]);
      found_q <= s_tdata_i[64];
      fslot_q <= s_tdata_i[72:65];
    end
    if (cmd_i.rd) begin
      idx_q <= rd_addr;
    end
  end

  dmwbnc_slot #(
    .ENTRIES (ENTRIES),
    .KW      (KW)
  ) u_slot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.load),
    .key_i   (key_in),
    .done_o  (slot_done),
    .slot_o  (slot)
  );

  assign in_range = (32'(fslot_q) < 32'(ENTRIES));
  assign rd_addr  = (op_q == dmwbnc_pkg::OP_FLUSH) ? IW'(fslot_q) : slot;

  // Clearing sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_addr_q <= clr_addr_q + IW'(1);
    end
  end

  // Entry RAM
  logic [EW-1:0] rd_word;
  logic [EW-1:0] new_word;
  logic          upd_we;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;

  assign ram_we    = cmd_i.clear | (cmd_i.decide & upd_we);
  assign ram_waddr = cmd_i.clear ? clr_addr_q : idx_q;
  assign ram_wdata = cmd_i.clear ? '0 : new_word;

  dmwbnc_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (rd_addr),
    .rdata_o (rd_word)
  );

  // Decision on the read entry
  logic          e_valid, e_dirty, e_disk;
  logic [KW-1:0] e_key;
  logic [VW-1:0] e_val;
  logic          hit;
  logic          n_valid, n_dirty, n_disk;
  logic [KW-1:0] n_key;
  logic [VW-1:0] n_val;
  logic          wb;
  logic [dmwbnc_pkg::KIND_W-1:0] m_kind;
  logic [KW-1:0] m_key;
  logic [VW-1:0] m_val;

  assign {e_valid, e_dirty, e_disk, e_key, e_val} = rd_word;
  assign hit      = e_valid && (e_key == key_q);
  assign new_word = {n_valid, n_dirty, n_disk, n_key, n_val};

  always_comb begin
    n_valid = e_valid;
    n_dirty = e_dirty;
    n_disk  = e_disk;
    n_key   = e_key;
    n_val   = e_val;
    upd_we  = 1'b0;
    wb      = 1'b0;
    m_kind  = dmwbnc_pkg::KIND_DONE;
    m_key   = '0;
    m_val   = '0;
    case (op_q)
      dmwbnc_pkg::OP_LOOKUP: begin
        m_key = key_q;
        if (hit) begin
          m_kind = dmwbnc_pkg::KIND_VALUE;
          m_val  = e_val;
        end else begin
          m_kind = dmwbnc_pkg::KIND_FETCH;
        end
      end
      dmwbnc_pkg::OP_STORE: begin
        if (hit) begin
          if (e_val != data_q) begin
            upd_we  = 1'b1;
            n_val   = data_q;
            n_dirty = 1'b1;
          end
        end else begin
          wb      = e_valid & e_dirty;
          upd_we  = 1'b1;
          n_valid = 1'b1;
          n_dirty = 1'b1;
          n_disk  = 1'b0;
          n_key   = key_q;
          n_val   = data_q;
        end
      end
      dmwbnc_pkg::OP_REMOVE: begin
        m_kind = dmwbnc_pkg::KIND_DELETE;
        m_key  = key_q;
        if (hit) begin
          upd_we  = 1'b1;
          n_valid = 1'b0;
          if (!e_disk) begin
            m_kind = dmwbnc_pkg::KIND_DONE;
            m_key  = '0;
          end
        end
      end
      dmwbnc_pkg::OP_FILL: begin
        m_key = key_q;
        if (!found_q) begin
          m_kind = dmwbnc_pkg::KIND_NOTFOUND;
        end else if (hit) begin
          m_kind = dmwbnc_pkg::KIND_VALUE;
          m_val  = e_val;
        end else begin
          wb      = e_valid & e_dirty;
          upd_we  = 1'b1;
          n_valid = 1'b1;
          n_dirty = 1'b0;
          n_disk  = 1'b1;
          n_key   = key_q;
          n_val   = data_q;
          m_kind  = dmwbnc_pkg::KIND_VALUE;
          m_val   = data_q;
        end
      end
      dmwbnc_pkg::OP_FLUSH: begin
        if (in_range && e_valid && e_dirty) begin
          wb      = 1'b1;
          upd_we  = 1'b1;
          n_dirty = 1'b0;
          n_disk  = 1'b1;
        end
      end
      default: begin
        m_kind = dmwbnc_pkg::KIND_DONE;
      end
    endcase
  end

  // Result registers
  logic [KW-1:0] wb_key_q;
  logic [VW-1:0] wb_val_q;
  logic [dmwbnc_pkg::KIND_W-1:0] main_kind_q;
  logic [KW-1:0] main_key_q;
  logic [VW-1:0] main_val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      wb_key_q    <= e_key;
      wb_val_q    <= e_val;
      main_kind_q <= m_kind;
      main_key_q  <= m_key;
      main_val_q  <= m_val;
    end
  end

  always_comb begin
    if (cmd_i.sel_main) begin
      m_tuser_o = main_kind_q;
      m_tdata_o = {32'(main_val_q), 32'(main_key_q)};
    end else begin
      m_tuser_o = dmwbnc_pkg::KIND_WRITEBACK;
      m_tdata_o = {32'(wb_val_q), 32'(wb_key_q)};
    end
  end

  assign m_tlast_o = cmd_i.sel_main;

  assign status_o.slot_done  = slot_done;
  assign status_o.clear_last = (clr_addr_q == IW'(ENTRIES - 1));
  assign status_o.need_wb    = wb;

endmodule

### rtl/dmwbnc_ctrl.sv
// ----------------------------------------------------------------------------
// dmwbnc_ctrl
// Controller: clearing sweep after reset, then accept, index, read, decide
// and up to two output beats per item.
// ----------------------------------------------------------------------------
module dmwbnc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  input  dmwbnc_pkg::status_t status_i,
  output dmwbnc_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_INDEX   = 3'd2;
  localparam logic [2:0] ST_DECIDE  = 3'd3;
  localparam logic [2:0] ST_EMIT_WB = 3'd4;
  localparam logic [2:0] ST_EMIT    = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    m_tvalid_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_INDEX;
        end
      end
      ST_INDEX: begin
        if (status_i.slot_done) begin
          cmd_o.rd = 1'b1;
          state_d  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = status_i.need_wb ? ST_EMIT_WB : ST_EMIT;
      end
      ST_EMIT_WB: begin
        m_tvalid_o = 1'b1;
        if (m_tready_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        m_tvalid_o     = 1'b1;
        cmd_o.sel_main = 1'b1;
        if (m_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/direct_mapped_writeback_name_cache.sv
// ----------------------------------------------------------------------------
// direct_mapped_writeback_name_cache
// Direct-mapped write-back cache of key/value pairs in front of a backing
// store; one slot per key modulo ENTRIES.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream carries one operation per beat (tuser = operation; tdata =
//    key, data, found, slot). Master stream returns one or two result beats
//    per operation (tuser = kind; tdata = key, value); tlast marks the final
//    beat, a write-back beat always comes first with tlast low.
//  - After reset the block sweeps the entry RAM, writing one slot per cycle;
//    tready stays low until every slot has been cleared.
//  - One operation at a time. The first result beat is offered after the index
//    register, the RAM read and the slot update; depths that are not a power
//    of two also pass through the reciprocal multiply of the index unit.
//  - A stalled receiver holds the current result beat; tready on the slave
//    side stays low until the last beat of the item has gone.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_name_cache #(
  parameter int unsigned ENTRIES    = 256,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Operation beats
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [31:0] key, [63:32] data, [64] found, [72:65] slot, [79:73] zero
  input  logic [dmwbnc_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // [2:0] operation
  input  logic [dmwbnc_pkg::OP_W-1:0]          s_axis_tuser_i,
  // Result beats
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [31:0] out_key, [63:32] out_value
  output logic [dmwbnc_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  // [2:0] kind
  output logic [dmwbnc_pkg::KIND_W-1:0]        m_axis_tuser_o,
  output logic                                 m_axis_tlast_o
);

  dmwbnc_pkg::cmd_t    cmd;
  dmwbnc_pkg::status_t status;

  // Datapath: item registers, index unit, entry RAM, decision, results
  dmwbnc_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .s_tdata_i (s_axis_tdata_i),
    .s_tuser_i (s_axis_tuser_i),
    .m_tdata_o (m_axis_tdata_o),
    .m_tuser_o (m_axis_tuser_o),
    .m_tlast_o (m_axis_tlast_o)
  );

  // Controller: sequencing and both handshakes
  dmwbnc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

endmodule
